// File: hdl/mibc_pkg.sv
package mibc_pkg;

    localparam int CMD_W        = 3;
    localparam int ADDR_W       = 16;
    localparam int BYTE_W       = 8;
    localparam int KEY_W        = 9;
    localparam int TIMER_W      = 12;
    localparam int BEEP_W       = 18;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 18;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ    = 3'd0,
        CMD_WRITE   = 3'd1,
        CMD_TICK    = 3'd2,
        CMD_FDC     = 3'd3,
        CMD_LP      = 3'd4,
        CMD_KEY     = 3'd5,
        CMD_FDC_ACK = 3'd6
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMER_PERIOD = 1'b0,
        CFG_BEEP_LENGTH  = 1'b1
    } t_cfg_idx;

    localparam logic [ADDR_W-1:0] ADDR_KEY_STAT = 16'hfd00;
    localparam logic [ADDR_W-1:0] ADDR_KEY_CODE = 16'hfd01;
    localparam logic [ADDR_W-1:0] ADDR_IRQ_MASK = 16'hfd02;
    localparam logic [ADDR_W-1:0] ADDR_IRQ_BEEP = 16'hfd03;
    localparam logic [ADDR_W-1:0] ADDR_ROM_SEL  = 16'hfd0f;

    localparam logic [TIMER_W-1:0] TIMER_PERIOD_RST = 12'd2034;
    localparam logic [TIMER_W-1:0] TIMER_MAX        = '1;
    localparam logic [TIMER_W-1:0] TIMER_ONE        = 12'd1;
    localparam logic [BEEP_W-1:0]  BEEP_LENGTH_RST  = 18'd205000;
    localparam logic [BEEP_W-1:0]  BEEP_ONE         = 18'd1;

    localparam logic [BYTE_W-1:0]  BYTE_ALL_ONES    = 8'hff;
    localparam logic [BYTE_W-1:0]  KEY_STAT_PRESSED = 8'h7f;
    localparam int                 KEY_NONE_BIT     = 8;

    // enable register bit positions
    localparam int EN_KEY   = 0;
    localparam int EN_LP    = 1;
    localparam int EN_TIMER = 2;
    localparam int EN_FDC   = 4;

    // FD03 write bits
    localparam int BEEP_SPK_BIT    = 0;
    localparam int BEEP_SINGLE_BIT = 6;
    localparam int BEEP_CONT_BIT   = 7;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] write_data;
        logic [KEY_W-1:0]  key_code;
        logic              other_irq;
    } t_req;

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              handled;
        logic              irq_request;
        logic              beep_active;
        logic              speaker_on;
        logic              basic_rom_on;
        logic [BYTE_W-1:0] enable_bits;
    } t_rsp;

endpackage

// File: hdl/mibc_req_if.sv
interface mibc_req_if import mibc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] write_data;
    logic [KEY_W-1:0]  key_code;
    logic              other_irq;

    modport source (
        output valid, cmd, addr, write_data, key_code, other_irq,
        input  ready
    );
    modport sink (
        input  valid, cmd, addr, write_data, key_code, other_irq,
        output ready
    );
endinterface

// File: hdl/mibc_rsp_if.sv
interface mibc_rsp_if import mibc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_data;
    logic              handled;
    logic              irq_request;
    logic              beep_active;
    logic              speaker_on;
    logic              basic_rom_on;
    logic [BYTE_W-1:0] enable_bits;

    modport source (
        output valid, read_data, handled, irq_request, beep_active, speaker_on,
               basic_rom_on, enable_bits,
        input  ready
    );
    modport sink (
        input  valid, read_data, handled, irq_request, beep_active, speaker_on,
               basic_rom_on, enable_bits,
        output ready
    );
endinterface

// File: hdl/mibc_core.sv
module mibc_core import mibc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_accept,
    input  t_req                  i_req,
    output t_rsp                  o_rsp
);

    logic [TIMER_W-1:0] r_period, n_period;
    logic [BEEP_W-1:0]  r_blen,   n_blen;
    logic [BYTE_W-1:0]  r_en,     n_en;
    logic               r_key,    n_key;
    logic               r_lp,     n_lp;
    logic               r_tick,   n_tick;
    logic               r_disk,   n_disk;
    logic               r_beep,   n_beep;
    logic               r_spk,    n_spk;
    logic               r_rom,    n_rom;
    logic [TIMER_W-1:0] r_tcnt,   n_tcnt;
    logic               r_long,   n_long;
    logic [BEEP_W-1:0]  r_bcnt,   n_bcnt;

    logic [BYTE_W-1:0]  rd;
    logic               hit;
    logic [BYTE_W-1:0]  status_now;
    t_cmd               cmd;

    assign cmd = t_cmd'(i_req.cmd);

    // active-low FD03 status
    assign status_now = ~{4'b0000, r_disk | i_req.other_irq, r_tick, r_lp,
                          r_key & r_en[EN_KEY]};

    always_comb begin
        n_period = r_period;
        n_blen   = r_blen;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TIMER_PERIOD: n_period = i_cfg_data[TIMER_W-1:0];
                CFG_BEEP_LENGTH:  n_blen   = i_cfg_data[BEEP_W-1:0];
            endcase
        end
    end

    always_comb begin
        n_en   = r_en;
        n_key  = r_key;
        n_lp   = r_lp;
        n_tick = r_tick;
        n_disk = r_disk;
        n_beep = r_beep;
        n_spk  = r_spk;
        n_rom  = r_rom;
        n_tcnt = r_tcnt;
        n_long = r_long;
        n_bcnt = r_bcnt;
        rd     = '0;
        hit    = 1'b0;
        unique case (cmd)
            CMD_READ: begin
                unique case (i_req.addr)
                    ADDR_KEY_STAT: begin
                        rd  = i_req.key_code[KEY_NONE_BIT] ? BYTE_ALL_ONES : KEY_STAT_PRESSED;
                        hit = 1'b1;
                    end
                    ADDR_KEY_CODE: begin
                        rd    = i_req.key_code[BYTE_W-1:0];
                        n_key = 1'b0;
                        hit   = 1'b1;
                    end
                    ADDR_IRQ_BEEP: begin
                        rd     = status_now;
                        n_lp   = 1'b0;
                        n_tick = 1'b0;
                        hit    = 1'b1;
                    end
                    ADDR_ROM_SEL: begin
                        rd    = BYTE_ALL_ONES;
                        n_rom = 1'b1;
                        hit   = 1'b1;
                    end
                    default: ;
                endcase
            end
            CMD_WRITE: begin
                unique case (i_req.addr)
                    ADDR_IRQ_MASK: begin
                        n_en = i_req.write_data;
                        hit  = 1'b1;
                    end
                    ADDR_IRQ_BEEP: begin
                        n_spk = i_req.write_data[BEEP_SPK_BIT];
                        if (i_req.write_data[BEEP_SINGLE_BIT]) begin
                            n_beep = 1'b1;
                            n_bcnt = (r_blen == '0) ? BEEP_ONE : r_blen;
                        end else begin
                            n_beep = i_req.write_data[BEEP_CONT_BIT];
                        end
                        hit = 1'b1;
                    end
                    ADDR_ROM_SEL: begin
                        n_rom = 1'b0;
                        hit   = 1'b1;
                    end
                    default: ;
                endcase
            end
            CMD_TICK: begin
                if (r_tcnt > TIMER_ONE) begin
                    n_tcnt = r_tcnt - TIMER_ONE;
                end else begin
                    n_tick = r_en[EN_TIMER];
                    n_long = ~r_long;
                    if (!r_long && r_period == TIMER_MAX) begin
                        n_tcnt = TIMER_MAX;
                    end else begin
                        n_tcnt = r_period + {{(TIMER_W-1){1'b0}}, ~r_long};
                    end
                end
                if (r_bcnt != '0) begin
                    n_bcnt = r_bcnt - BEEP_ONE;
                    if (r_bcnt == BEEP_ONE) begin
                        n_beep = 1'b0;
                    end
                end
            end
            CMD_FDC: begin
                if (r_en[EN_FDC]) begin
                    n_disk = 1'b1;
                end
            end
            CMD_LP: begin
                if (r_en[EN_LP]) begin
                    n_lp = 1'b1;
                end
            end
            CMD_KEY:     n_key  = 1'b1;
            CMD_FDC_ACK: n_disk = 1'b0;
            default: ;
        endcase
    end

    always_comb begin
        o_rsp.read_data    = rd;
        o_rsp.handled      = hit;
        o_rsp.irq_request  = (n_key & n_en[EN_KEY]) | n_lp | n_tick | n_disk
                             | i_req.other_irq;
        o_rsp.beep_active  = n_beep;
        o_rsp.speaker_on   = n_spk;
        o_rsp.basic_rom_on = n_rom;
        o_rsp.enable_bits  = n_en;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= TIMER_PERIOD_RST;
            r_blen   <= BEEP_LENGTH_RST;
            r_en     <= '0;
            r_key    <= 1'b0;
            r_lp     <= 1'b0;
            r_tick   <= 1'b0;
            r_disk   <= 1'b0;
            r_beep   <= 1'b0;
            r_spk    <= 1'b0;
            r_rom    <= 1'b1;
            r_tcnt   <= TIMER_PERIOD_RST;
            r_long   <= 1'b0;
            r_bcnt   <= '0;
        end else begin
            r_period <= n_period;
            r_blen   <= n_blen;
            if (i_accept) begin
                r_en   <= n_en;
                r_key  <= n_key;
                r_lp   <= n_lp;
                r_tick <= n_tick;
                r_disk <= n_disk;
                r_beep <= n_beep;
                r_spk  <= n_spk;
                r_rom  <= n_rom;
                r_tcnt <= n_tcnt;
                r_long <= n_long;
                r_bcnt <= n_bcnt;
            end
        end
    end

    a_fd03_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && cmd == CMD_READ && i_req.addr == ADDR_IRQ_BEEP |=> !r_lp && !r_tick)
        else $error("FD03 read did not clear printer and timer flags");

    a_reload_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && cmd == CMD_TICK && r_tcnt <= TIMER_ONE |=> r_long != $past(r_long))
        else $error("timer reload did not alternate the period");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> $stable(r_en) && $stable(r_tcnt) && $stable(r_bcnt) && $stable(r_key))
        else $error("state changed without a transfer");

    a_single_beep_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && cmd == CMD_WRITE && i_req.addr == ADDR_IRQ_BEEP
        && i_req.write_data[BEEP_SINGLE_BIT] |=> r_beep && r_bcnt != '0)
        else $error("single beep did not start");

endmodule

// File: hdl/mibc_skid.sv
module mibc_skid import mibc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_rsp i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_rsp o_data
);

    logic r_out_vld, n_out_vld;
    logic r_skd_vld, n_skd_vld;
    t_rsp r_out, n_out;
    t_rsp r_skd, n_skd;
    logic take;
    logic push;

    assign o_ready = ~r_skd_vld;
    assign o_valid = r_out_vld;
    assign o_data  = r_out;
    assign take    = r_out_vld & i_ready;
    assign push    = i_valid & ~r_skd_vld;

    always_comb begin
        n_out_vld = r_out_vld;
        n_skd_vld = r_skd_vld;
        n_out     = r_out;
        n_skd     = r_skd;
        if (take) begin
            if (r_skd_vld) begin
                n_out     = r_skd;
                n_skd_vld = 1'b0;
            end else if (push) begin
                n_out = i_data;
            end else begin
                n_out_vld = 1'b0;
            end
        end else if (push) begin
            if (!r_out_vld) begin
                n_out     = i_data;
                n_out_vld = 1'b1;
            end else begin
                n_skd     = i_data;
                n_skd_vld = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
            r_skd_vld <= n_skd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_skd <= n_skd;
    end

endmodule

// File: hdl/main_io_irq_beep_controller_core.sv
// Main-CPU I/O block: interrupt enables (FD02), IRQ status and beeper (FD03),
// keyboard status/code (FD00/FD01), BASIC ROM select (FD0F) and the periodic
// timer driven by microsecond tick commands. Each accepted request produces
// exactly one response, registered in the output buffer. A new request
// can be taken every cycle while the buffer's skid entry is free: all state
// is updated when a request is accepted, and a two-entry output buffer keeps
// the request side ready while one response waits. Register writes on the
// config port take effect at once; a new timer period applies at the next
// reload, a new beep length at the next single beep.
module main_io_irq_beep_controller_core import mibc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mibc_req_if.sink              i_req,
    mibc_rsp_if.source            o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_req req;
    t_rsp rsp_core;
    t_rsp rsp_out;
    logic req_ready;
    logic accept;

    assign req.cmd        = i_req.cmd;
    assign req.addr       = i_req.addr;
    assign req.write_data = i_req.write_data;
    assign req.key_code   = i_req.key_code;
    assign req.other_irq  = i_req.other_irq;

    assign i_req.ready = req_ready;
    assign accept      = i_req.valid & req_ready;

    mibc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_req      (req),
        .o_rsp      (rsp_core)
    );

    mibc_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (req_ready),
        .i_data  (rsp_core),
        .o_valid (o_rsp.valid),
        .i_ready (o_rsp.ready),
        .o_data  (rsp_out)
    );

    assign o_rsp.read_data    = rsp_out.read_data;
    assign o_rsp.handled      = rsp_out.handled;
    assign o_rsp.irq_request  = rsp_out.irq_request;
    assign o_rsp.beep_active  = rsp_out.beep_active;
    assign o_rsp.speaker_on   = rsp_out.speaker_on;
    assign o_rsp.basic_rom_on = rsp_out.basic_rom_on;
    assign o_rsp.enable_bits  = rsp_out.enable_bits;

endmodule
